// ===== src/ucr_pkg.sv =====
// Shared types and constants for the setup-packet capture ring.
// Used by ucr_ctrl, ucr_out, ucr_checker and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ucr_pkg;

	// Field widths
	localparam int unsigned TS_W  = 32;
	localparam int unsigned PKT_W = 64;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned REC_W = TS_W + PKT_W;

	// Request opcodes
	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_DUMP    = 1'b1;

	// Capture filter constants
	localparam logic [7:0]  CTRL_EP       = 8'h00;
	localparam logic [7:0]  TYPE_MASK     = 8'h60;
	localparam logic [7:0]  TYPE_STANDARD = 8'h00;
	localparam logic [15:0] SETUP_LEN     = 16'd8;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Sequencer to output stage: read issue and empty-result load
	typedef struct packed {
		logic             issue;
		logic             last;
		logic             empty;
		logic [CNT_W-1:0] count;
	} ucr_rd_req_t;

	// Output stage to sequencer: room for the next read or empty result
	typedef struct packed {
		logic issue_ok;
		logic empty_ok;
	} ucr_out_sts_t;

endpackage

`default_nettype wire

// ===== src/ucr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ucr_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 16
) (
	input  wire                                       clk,
	input  wire                                       wr_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire [WIDTH-1:0]                           wr_data,
	input  wire                                       rd_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ucr_ctrl.sv =====
// Capture filter, write pointer, saturating counter and dump sequencer.
// Depends on ucr_pkg; drives the ring RAM and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module ucr_ctrl #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire                                             in_valid,
	output logic                                            in_stall,
	input  wire                                             opcode,
	input  wire                                             read_ok,
	input  wire  [7:0]                                      endpoint,
	input  wire  [15:0]                                     read_length,
	input  wire                                             count_wanted,
	input  wire                                             data_present,
	input  wire  [ucr_pkg::TS_W-1:0]                        timestamp_ms,
	input  wire  [ucr_pkg::PKT_W-1:0]                       setup_packet,
	output logic                                            wr_en,
	output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
	output logic [ucr_pkg::REC_W-1:0]                       wr_data,
	output logic                                            rd_en,
	output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
	output ucr_pkg::ucr_rd_req_t                            req,
	input  ucr_pkg::ucr_out_sts_t                           sts
);

	import ucr_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned RW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0]    LAST_SLOT = AW'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
	localparam logic [RW-1:0]    CAP_RW    = RW'(CAPACITY);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	logic [1:0]       state_q;
	logic [AW-1:0]    wp_q;
	logic [CNT_W-1:0] total_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [RW-1:0]    remain_q;
	logic [CNT_W-1:0] dump_cnt_q;

	logic          accept;
	logic          hit;
	logic          do_dump;
	logic [RW-1:0] n_entries;
	logic [AW-1:0] start_slot;
	logic          issue;
	logic          last_rd;

	// Requests are taken only while the sequencer is idle
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Standard setup read on endpoint 0
	assign hit = read_ok && (endpoint == CTRL_EP) && (read_length == SETUP_LEN) &&
		!count_wanted && data_present &&
		((setup_packet[7:0] & TYPE_MASK) == TYPE_STANDARD);

	assign wr_en   = accept && (opcode == OP_OBSERVE) && hit;
	assign wr_addr = wp_q;
	assign wr_data = {setup_packet, timestamp_ms};

	// Dump extent: oldest entry first once the ring has wrapped
	assign do_dump    = accept && (opcode == OP_DUMP);
	assign n_entries  = (total_q < CAP_CNT) ? total_q[RW-1:0] : CAP_RW;
	assign start_slot = (total_q <= CAP_CNT) ? '0 : wp_q;

	// One RAM read per cycle when the output stage has room
	assign issue   = (state_q == ST_READ) && sts.issue_ok;
	assign last_rd = (remain_q == RW'(1));
	assign rd_en   = issue;
	assign rd_addr = rd_ptr_q;

	assign req.issue = issue;
	assign req.last  = last_rd;
	assign req.empty = (state_q == ST_EMPTY) && sts.empty_ok;
	assign req.count = dump_cnt_q;

	// Write pointer and saturating capture counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			total_q <= '0;
		end else if (wr_en) begin
			wp_q <= (wp_q == LAST_SLOT) ? '0 : wp_q + AW'(1);
			if (total_q != CNT_MAX) begin
				total_q <= total_q + CNT_W'(1);
			end
		end
	end

	// Dump sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_ptr_q   <= '0;
			remain_q   <= '0;
			dump_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_dump) begin
						dump_cnt_q <= total_q;
						rd_ptr_q   <= start_slot;
						remain_q   <= n_entries;
						state_q    <= (n_entries == '0) ? ST_EMPTY : ST_READ;
					end
				end
				ST_READ: begin
					if (issue) begin
						remain_q <= remain_q - RW'(1);
						rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
						if (last_rd) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMPTY: begin
					if (sts.empty_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/ucr_out.sv =====
// Output stage: tracks RAM read data in flight, unpacks it into the result
// register and holds it under stall. Depends on ucr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucr_out (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ucr_pkg::ucr_rd_req_t         req,
	output ucr_pkg::ucr_out_sts_t        sts,
	input  wire  [ucr_pkg::REC_W-1:0]    rd_data,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [ucr_pkg::TS_W-1:0]     entry_timestamp_ms,
	output logic [7:0]                   entry_request_type,
	output logic [7:0]                   entry_request,
	output logic [15:0]                  entry_value,
	output logic [15:0]                  entry_index,
	output logic [15:0]                  entry_length,
	output logic                         entry_valid,
	output logic                         last_entry,
	output logic [ucr_pkg::CNT_W-1:0]    capture_count
);

	import ucr_pkg::*;

	logic             pend_s1;
	logic             last_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             out_valid_q;
	logic [TS_W-1:0]  ts_q;
	logic [PKT_W-1:0] pkt_q;
	logic             ent_valid_q;
	logic             last_q;
	logic [CNT_W-1:0] cnt_q;

	logic free;
	logic move;

	// Result register frees up when empty or taken this cycle
	assign free = !out_valid_q || !out_stall;
	assign move = pend_s1 && free;

	assign sts.issue_ok = !pend_s1 || move;
	assign sts.empty_ok = !pend_s1 && free;

	// Read-in-flight tag; RAM data holds until the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (req.issue) begin
			pend_s1 <= 1'b1;
		end else if (move) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.issue) begin
			last_s1 <= req.last;
			cnt_s1  <= req.count;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move || req.empty) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: stored entry or the empty-dump marker
	always_ff @(posedge clk) begin
		if (move) begin
			ts_q        <= rd_data[TS_W-1:0];
			pkt_q       <= rd_data[REC_W-1:TS_W];
			ent_valid_q <= 1'b1;
			last_q      <= last_s1;
			cnt_q       <= cnt_s1;
		end else if (req.empty) begin
			ts_q        <= '0;
			pkt_q       <= '0;
			ent_valid_q <= 1'b0;
			last_q      <= 1'b1;
			cnt_q       <= req.count;
		end
	end

	// Little-endian unpack of the setup bytes
	assign out_valid          = out_valid_q;
	assign entry_timestamp_ms = ts_q;
	assign entry_request_type = pkt_q[7:0];
	assign entry_request      = pkt_q[15:8];
	assign entry_value        = pkt_q[31:16];
	assign entry_index        = pkt_q[47:32];
	assign entry_length       = pkt_q[63:48];
	assign entry_valid        = ent_valid_q;
	assign last_entry         = last_q;
	assign capture_count      = cnt_q;

endmodule

`default_nettype wire

// ===== src/usb_setup_capture_ring.sv =====
// Top level of the setup-packet capture ring.
// Instantiates ucr_ctrl, ucr_ram and ucr_out; depends on ucr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Records standard SETUP packets read from endpoint 0 into a ring of CAPACITY
// entries (timestamp plus the eight raw bytes), overwriting the oldest entry
// once full, and keeps a saturating 32-bit capture count. An observe request
// gives no result. A dump request returns the stored entries oldest first, the
// final one flagged by last_entry, each carrying the capture count at the time
// of the dump; with nothing stored it returns one result with entry_valid low.
// Entries live in a single RAM with one write and one registered read port. A
// dump reads one entry per cycle while the result register has room and holds
// in_stall high until its last read is issued, or its empty result is loaded;
// with out_stall low, results stream at one per cycle. No clearing pass is
// needed after reset.
module usb_setup_capture_ring #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         opcode,
	input  wire                         read_ok,
	input  wire  [7:0]                  endpoint,
	input  wire  [15:0]                 read_length,
	input  wire                         count_wanted,
	input  wire                         data_present,
	input  wire  [ucr_pkg::TS_W-1:0]    timestamp_ms,
	input  wire  [ucr_pkg::PKT_W-1:0]   setup_packet,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [ucr_pkg::TS_W-1:0]    entry_timestamp_ms,
	output logic [7:0]                  entry_request_type,
	output logic [7:0]                  entry_request,
	output logic [15:0]                 entry_value,
	output logic [15:0]                 entry_index,
	output logic [15:0]                 entry_length,
	output logic                        entry_valid,
	output logic                        last_entry,
	output logic [ucr_pkg::CNT_W-1:0]   capture_count
);

	import ucr_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [REC_W-1:0]  wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [REC_W-1:0]  rd_data;
	ucr_rd_req_t       req;
	ucr_out_sts_t      sts;

	// Filter, pointers and dump sequencing
	ucr_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.read_ok      (read_ok),
		.endpoint     (endpoint),
		.read_length  (read_length),
		.count_wanted (count_wanted),
		.data_present (data_present),
		.timestamp_ms (timestamp_ms),
		.setup_packet (setup_packet),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.req          (req),
		.sts          (sts)
	);

	// Entry store: {setup packet, timestamp}
	ucr_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register and unpack
	ucr_out u_out (
		.clk                (clk),
		.arst_n             (arst_n),
		.req                (req),
		.sts                (sts),
		.rd_data            (rd_data),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.entry_timestamp_ms (entry_timestamp_ms),
		.entry_request_type (entry_request_type),
		.entry_request      (entry_request),
		.entry_value        (entry_value),
		.entry_index        (entry_index),
		.entry_length       (entry_length),
		.entry_valid        (entry_valid),
		.last_entry         (last_entry),
		.capture_count      (capture_count)
	);

endmodule

`default_nettype wire

// ===== src/ucr_checker.sv =====
// Port-level checks for the setup-packet capture ring, bound to the top level.
// Depends on ucr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module ucr_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        out_valid,
	input wire                        out_stall,
	input wire                        entry_valid,
	input wire                        last_entry,
	input wire [ucr_pkg::TS_W-1:0]    entry_timestamp_ms,
	input wire [ucr_pkg::CNT_W-1:0]   capture_count
);

	import ucr_pkg::*;

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(entry_timestamp_ms) && $stable(capture_count)
			&& $stable(entry_valid) && $stable(last_entry))
		else $error("stalled result changed");

	// An empty dump gives a single final result with a zero count
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> last_entry && (capture_count == '0))
		else $error("empty-dump result malformed");

	// A stored entry exists only after at least one capture
	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> (capture_count != '0))
		else $error("entry reported with zero capture count");

endmodule

bind usb_setup_capture_ring ucr_checker u_ucr_checker (.*);

`default_nettype wire
